[rtl/sab_pkg.sv]
`default_nettype none

package sab_pkg;

    localparam int DATA_W        = 32;
    localparam int WIDTH_DEFAULT = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] low_one;
        logic signed [DATA_W-1:0] high_one;
        logic signed [DATA_W-1:0] low_two;
        logic signed [DATA_W-1:0] high_two;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_low;
        logic signed [DATA_W-1:0] out_high;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_JOIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       prep;
        logic       step;
        logic       merge;
        logic [1:0] pair;
    } dp_cmd_t;

    typedef struct packed {
        logic last_bit;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/sab_ctrl.sv]
`default_nettype none

module sab_ctrl
    import sab_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t     state_reg, state_next;
    logic [1:0] pair_reg, pair_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pair_reg  <= '0;
        end else begin
            state_reg <= state_next;
            pair_reg  <= pair_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pair_next  = pair_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                    pair_next  = '0;
                end
            end
            ST_PREP: state_next = ST_SCAN;
            ST_SCAN: begin
                if (status.last_bit) begin
                    state_next = ST_JOIN;
                end
            end
            ST_JOIN: begin
                if (pair_reg == 2'd3) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_PREP;
                    pair_next  = pair_reg + 2'd1;
                end
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        cmd       = '0;
        cmd.pair  = pair_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_PREP: cmd.prep  = 1'b1;
            ST_SCAN: cmd.step  = 1'b1;
            ST_JOIN: cmd.merge = 1'b1;
            ST_DONE: m_valid   = 1'b1;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[rtl/sab_dpath.sv]
`default_nettype none

module sab_dpath
    import sab_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire dp_cmd_t  cmd,
    input  wire in_word_t s_data,
    output dp_status_t    status,
    output out_word_t     m_data
);

    localparam int BW = $clog2(WIDTH);

    logic [WIDTH-1:0] x_lo0_reg, x_hi0_reg, x_lo1_reg, x_hi1_reg;
    logic [WIDTH-1:0] y_lo0_reg, y_hi0_reg, y_lo1_reg, y_hi1_reg;
    logic [WIDTH-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [WIDTH-1:0] la_reg, lc_reg, hb_reg, hd_reg;
    logic [WIDTH-1:0] res_lo_reg, res_hi_reg;
    logic             lo_stop_reg, hi_stop_reg;
    logic [BW-1:0]    bit_reg;

    logic [WIDTH-1:0] in_lo1, in_hi1, in_lo2, in_hi2;
    logic             zero1, zero2;
    logic [WIDTH-1:0] one_w, m, below, above;
    logic [WIDTH-1:0] t_la, t_lc, t_hb, t_hd;
    logic [WIDTH-1:0] and_lo, and_hi;
    logic             sel_i, sel_j;

    function automatic logic [DATA_W-1:0] to_out(input logic [WIDTH-1:0] v);
        logic signed [WIDTH-1:0] sv;
        logic signed [63:0]      ext;
        sv  = $signed(v);
        ext = 64'(sv);
        return ext[DATA_W-1:0];
    endfunction

    assign in_lo1 = WIDTH'($unsigned(s_data.low_one));
    assign in_hi1 = WIDTH'($unsigned(s_data.high_one));
    assign in_lo2 = WIDTH'($unsigned(s_data.low_two));
    assign in_hi2 = WIDTH'($unsigned(s_data.high_two));

    assign zero1 = (in_lo1[WIDTH-1] || (in_lo1 == '0)) && !in_hi1[WIDTH-1];
    assign zero2 = (in_lo2[WIDTH-1] || (in_lo2 == '0)) && !in_hi2[WIDTH-1];

    assign one_w = WIDTH'(1);
    assign m     = one_w << bit_reg;
    assign below = m - one_w;
    assign above = ~below;

    assign t_la = (la_reg | m) & above;
    assign t_lc = (lc_reg | m) & above;
    assign t_hb = (hb_reg & ~m) | below;
    assign t_hd = (hd_reg & ~m) | below;

    assign and_lo = la_reg & lc_reg;
    assign and_hi = hb_reg & hd_reg;

    assign sel_i = cmd.pair[1];
    assign sel_j = cmd.pair[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_stop_reg <= 1'b0;
            hi_stop_reg <= 1'b0;
            bit_reg     <= '0;
        end else begin
            if (cmd.load) begin
                x_lo0_reg  <= in_lo1;
                x_hi0_reg  <= zero1 ? '1 : in_hi1;
                x_lo1_reg  <= zero1 ? '0 : in_lo1;
                x_hi1_reg  <= in_hi1;
                y_lo0_reg  <= in_lo2;
                y_hi0_reg  <= zero2 ? '1 : in_hi2;
                y_lo1_reg  <= zero2 ? '0 : in_lo2;
                y_hi1_reg  <= in_hi2;
                res_lo_reg <= in_lo1;
                res_hi_reg <= zero1 ? '1 : in_hi1;
            end
            if (cmd.prep) begin
                a_reg       <= sel_i ? x_lo1_reg : x_lo0_reg;
                b_reg       <= sel_i ? x_hi1_reg : x_hi0_reg;
                c_reg       <= sel_j ? y_lo1_reg : y_lo0_reg;
                d_reg       <= sel_j ? y_hi1_reg : y_hi0_reg;
                la_reg      <= sel_i ? x_lo1_reg : x_lo0_reg;
                hb_reg      <= sel_i ? x_hi1_reg : x_hi0_reg;
                lc_reg      <= sel_j ? y_lo1_reg : y_lo0_reg;
                hd_reg      <= sel_j ? y_hi1_reg : y_hi0_reg;
                lo_stop_reg <= 1'b0;
                hi_stop_reg <= 1'b0;
                bit_reg     <= BW'(WIDTH - 1);
            end
            if (cmd.step) begin
                bit_reg <= bit_reg - BW'(1);
                if (!lo_stop_reg && ((~la_reg & ~lc_reg & m) != '0)) begin
                    if (t_la <= b_reg) begin
                        la_reg      <= t_la;
                        lo_stop_reg <= 1'b1;
                    end else if (t_lc <= d_reg) begin
                        lc_reg      <= t_lc;
                        lo_stop_reg <= 1'b1;
                    end
                end
                if (!hi_stop_reg) begin
                    if ((hb_reg & ~hd_reg & m) != '0) begin
                        if (t_hb >= a_reg) begin
                            hb_reg      <= t_hb;
                            hi_stop_reg <= 1'b1;
                        end
                    end else if ((~hb_reg & hd_reg & m) != '0) begin
                        if (t_hd >= c_reg) begin
                            hd_reg      <= t_hd;
                            hi_stop_reg <= 1'b1;
                        end
                    end
                end
            end
            if (cmd.merge) begin
                if ($signed(and_lo) < $signed(res_lo_reg)) begin
                    res_lo_reg <= and_lo;
                end
                if ($signed(res_hi_reg) < $signed(and_hi)) begin
                    res_hi_reg <= and_hi;
                end
            end
        end
    end

    assign status.last_bit = (bit_reg == '0);

    assign m_data.out_low  = to_out(res_lo_reg);
    assign m_data.out_high = to_out(res_hi_reg);

endmodule

`default_nettype wire

[rtl/signed_and_interval_bounds_top.sv]
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_data  (in_word_t: two signed intervals)
// m_       out        m_valid / m_ready   m_data  (out_word_t: bound of the AND)
//
// One word is worked on in four passes, one for each of the four part pairs: a load step,
// the one-bit-per-cycle bound scan over all WIDTH bits and a join step.
// aresetn is synchronous and active low; it returns the controller to idle.
// A result is held on m_data until m_ready; no new word is taken until then.
`default_nettype none

module signed_and_interval_bounds_top
    import sab_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEFAULT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_word_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_word_t     m_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sab_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .status  (status),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
